// ===== hdl/phcsu_pkg.sv =====
// ----------------------------------------------------------------------------
// phcsu_pkg
// Shared transaction types and constants for the phantom clock unlock unit.
// ----------------------------------------------------------------------------
`default_nettype none

package phcsu_pkg;

    localparam int unsigned KEY_BITS = 64;
    localparam int unsigned POS_W    = $clog2(KEY_BITS);

    // Unlock key, bit 0 is compared first.
    localparam logic [KEY_BITS-1:0] UNLOCK_KEY = 64'h5CA3_3AC5_5CA3_3AC5;

    localparam logic [1:0] CMD_ZERO  = 2'd0;
    localparam logic [1:0] CMD_ONE   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_WRITE = 2'd3;

    typedef struct packed {
        logic [1:0] command;
        logic       write_bit;
        logic [5:0] now_seconds;
        logic [5:0] now_minutes;
        logic [4:0] now_hours;
        logic [2:0] now_weekday;
        logic [4:0] now_day;
        logic [3:0] now_month_index;
        logic [7:0] now_years_since_1900;
    } t_in;

    typedef struct packed {
        logic read_bit;
        logic calendar_mode;
    } t_out;

endpackage

`default_nettype wire

// ===== hdl/phcsu_snap.sv =====
// ----------------------------------------------------------------------------
// phcsu_snap
// Convert the current binary time fields into the 64-bit BCD time snapshot.
// ----------------------------------------------------------------------------
`default_nettype none

module phcsu_snap (
    input  phcsu_pkg::t_in          i_item,
    output logic [63:0]             o_snap
);
    import phcsu_pkg::*;

    // BCD of an 8-bit value, truncated to 8 bits: tens digit keeps 4 bits.
    // Divide by ten through the reciprocal 205/2048, exact for 0..255.
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [15:0] prod;
        logic [4:0]  q;
        logic [7:0]  tens;
        logic [7:0]  r;
        prod = {8'd0, v} * 16'd205;
        q    = prod[15:11];
        tens = {3'd0, q} * 8'd10;
        r    = v - tens;
        return {q[3:0], r[3:0]};
    endfunction

    logic [4:0] month_plus_one;

    assign month_plus_one = {1'b0, i_item.now_month_index} + 5'd1;

    assign o_snap = {
        to_bcd(i_item.now_years_since_1900),
        to_bcd({3'd0, month_plus_one}),
        to_bcd({3'd0, i_item.now_day}),
        to_bcd({5'd0, i_item.now_weekday}),
        to_bcd({3'd0, i_item.now_hours}),
        to_bcd({2'd0, i_item.now_minutes}),
        to_bcd({2'd0, i_item.now_seconds}),
        8'h00
    };

endmodule

`default_nettype wire

// ===== hdl/phcsu_seq.sv =====
// ----------------------------------------------------------------------------
// phcsu_seq
// Key position, mode flag and snapshot register; forms one result per access.
// ----------------------------------------------------------------------------
`default_nettype none

module phcsu_seq (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  phcsu_pkg::t_in          i_item,
    input  logic [63:0]             i_snap,
    output phcsu_pkg::t_out         o_res,
    output logic                    o_mode
);
    import phcsu_pkg::*;

    logic [POS_W-1:0]    r_pos,  n_pos;
    logic                r_mode, n_mode;
    logic [KEY_BITS-1:0] r_snap, n_snap;
    logic                last_pos;
    logic                rbit;

    assign last_pos = (r_pos == POS_W'(KEY_BITS - 1));

    always_comb begin
        n_pos  = r_pos;
        n_mode = r_mode;
        n_snap = r_snap;
        rbit   = 1'b0;
        case (i_item.command)
            CMD_ZERO, CMD_ONE: begin
                if (UNLOCK_KEY[r_pos] == i_item.command[0]) begin
                    if (last_pos) begin
                        n_pos  = '0;
                        n_mode = 1'b1;
                        n_snap = i_snap;
                    end else begin
                        n_pos = r_pos + POS_W'(1);
                    end
                end else begin
                    n_pos  = '0;
                    n_mode = 1'b0;
                end
            end
            default: begin
                if (r_mode) begin
                    if (i_item.command == CMD_READ) begin
                        rbit = r_snap[r_pos];
                    end else begin
                        n_snap[r_pos] = i_item.write_bit;
                    end
                    if (last_pos) begin
                        n_pos  = '0;
                        n_mode = 1'b0;
                    end else begin
                        n_pos = r_pos + POS_W'(1);
                    end
                end else begin
                    n_pos = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_mode <= 1'b0;
        end else if (i_en) begin
            r_pos  <= n_pos;
            r_mode <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_snap <= n_snap;
        end
    end

    assign o_res.read_bit      = rbit;
    assign o_res.calendar_mode = n_mode;
    assign o_mode              = r_mode;

endmodule

`default_nettype wire

// ===== hdl/phantom_clock_serial_unlock_unit.sv =====
// ----------------------------------------------------------------------------
// phantom_clock_serial_unlock_unit
// Serial phantom clock: 64-bit unlock key, BCD time snapshot shifted out.
// Each transaction passes the input register, then the result register;
//   one result per input transaction.
// Throughput: 1 transaction per cycle unless the receiver stalls the output.
// Reset: synchronous active low; clears position, mode and valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module phantom_clock_serial_unlock_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  phcsu_pkg::t_in          i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output phcsu_pkg::t_out         o_out_data
);
    import phcsu_pkg::*;

    // Input register: holds one accepted transaction until the result
    // register can take its result.
    logic            r_in_vld;
    t_in             r_in;

    // Result register.
    logic            r_out_vld;
    t_out            r_out;

    logic            out_free;
    logic            adv;
    logic [63:0]     snap;
    t_out            res;
    logic            mode;

    // The result register frees up when empty or drained this cycle.
    assign out_free   = !r_out_vld || i_out_ready;
    // Advance the input stage into the state update and result register.
    assign adv        = r_in_vld && out_free;
    // Take a new transaction whenever the input register empties or moves on.
    assign o_in_ready = !r_in_vld || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Build the candidate snapshot from the registered time fields.
    phcsu_snap u_snap (
        .i_item (r_in),
        .o_snap (snap)
    );

    // Compare against the key, advance position, update mode and snapshot.
    phcsu_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_item  (r_in),
        .i_snap  (snap),
        .o_res   (res),
        .o_mode  (mode)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    // A held input transaction stays in the input register.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !out_free) |=> r_in_vld)
        else $error("input register dropped a pending transaction");

    // An advancing transaction always lands in the result register.
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_vld)
        else $error("advanced transaction produced no result");

    // The mode flag after an advance matches the reported calendar mode.
    a_mode_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> (mode == r_out.calendar_mode))
        else $error("reported calendar mode differs from state");

    // A read bit of one can only come from a data read.
    a_rbit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && res.read_bit) |-> (r_in.command == CMD_READ))
        else $error("read bit set on a non-read access");
`endif

endmodule

`default_nettype wire

// ===== bench/phantom_clock_serial_unlock_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// phantom_clock_serial_unlock_unit_test
// Self-checking bench for the phantom clock unlock unit. Drives key, read and
// write transactions under several idle and stall mixes. Checks every result
// against a local model of the key position, the mode flag and the snapshot.
// ----------------------------------------------------------------------------

module phantom_clock_serial_unlock_unit_test;

    import phcsu_pkg::*;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals around the unit
    // ------------------------------------------------------------------------
    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    t_out out_data;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    phantom_clock_serial_unlock_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // Idle mix of the current phase, in percent of cycles.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    int items_sent = 0;
    int fail_count = 0;

    // ------------------------------------------------------------------------
    // Local model of the unit: key position, calendar flag, time snapshot.
    // Updated when a transaction is driven; transactions are accepted in
    // drive order, so the model stays in step with the unit.
    // ------------------------------------------------------------------------
    logic [POS_W-1:0]    key_pos       = '0;
    logic                in_calendar   = 1'b0;
    logic [KEY_BITS-1:0] snapshot_bits = '0;

    t_out awaited_outputs[$];
    t_out oldest_expected;

    function automatic logic [7:0] to_bcd8(input int unsigned v);
        logic [31:0] bcd_word;
        bcd_word = ((v / 10) << 4) | (v % 10);
        return bcd_word[7:0];
    endfunction

    // Pattern command that matches the key at a given position.
    function automatic logic [1:0] key_command(input int unsigned pos);
        return UNLOCK_KEY[pos] ? CMD_ONE : CMD_ZERO;
    endfunction

    // Pattern command that breaks the key at a given position.
    function automatic logic [1:0] wrong_command(input int unsigned pos);
        return UNLOCK_KEY[pos] ? CMD_ZERO : CMD_ONE;
    endfunction

    function automatic t_out predict_access(input t_in acc);
        t_out res;
        res = '0;
        if (acc.command == CMD_ZERO || acc.command == CMD_ONE) begin
            if (UNLOCK_KEY[key_pos] == acc.command[0]) begin
                // The last key bit unlocks and latches the time as BCD bytes,
                // hundredths first and forced to zero.
                if (&key_pos) begin
                    in_calendar   = 1'b1;
                    snapshot_bits = {
                        to_bcd8(acc.now_years_since_1900),
                        to_bcd8(int'(acc.now_month_index) + 1),
                        to_bcd8(acc.now_day),
                        to_bcd8(acc.now_weekday),
                        to_bcd8(acc.now_hours),
                        to_bcd8(acc.now_minutes),
                        to_bcd8(acc.now_seconds),
                        8'h00
                    };
                end
                key_pos = key_pos + 1'b1;
            end else begin
                key_pos     = '0;
                in_calendar = 1'b0;
            end
        end else if (in_calendar) begin
            if (acc.command == CMD_READ) begin
                res.read_bit = snapshot_bits[key_pos];
            end else begin
                snapshot_bits[key_pos] = acc.write_bit;
            end
            // The data access at the last position ends the session.
            if (&key_pos) begin
                in_calendar = 1'b0;
            end
            key_pos = key_pos + 1'b1;
        end else begin
            // Data access while seeking: drop the partial key.
            key_pos = '0;
        end
        res.calendar_mode = in_calendar;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_in random_access(input logic [1:0] cmd);
        logic [63:0] raw;
        t_in         acc;
        raw         = {$urandom, $urandom};
        acc         = raw[$bits(t_in)-1:0];
        acc.command = cmd;
        return acc;
    endfunction

    // Drive one input transaction and hold it until the unit takes it. Valid
    // is only lowered for an idle gap, never between back-to-back items.
    task automatic send_item(input t_in acc);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= acc;
        awaited_outputs.push_back(predict_access(acc));
        items_sent++;
        do begin
            @(posedge clk);
        end while (!in_ready);
    endtask

    // Break the key at the current position, so the next run starts at zero.
    task automatic send_sync();
        send_item(random_access(wrong_command(key_pos)));
    endtask

    // Send matching key bits from the current position on. The bit at the
    // last position carries the time fields of stamp.
    task automatic send_key_run(input int n, input t_in stamp);
        t_in acc;
        repeat (n) begin
            if (&key_pos) begin
                acc = stamp;
            end else begin
                acc = random_access(CMD_ZERO);
            end
            acc.command = key_command(key_pos);
            send_item(acc);
        end
    endtask

    // Mostly reads and writes, with an occasional key bit that matches or
    // breaks the key at the current position.
    task automatic send_data_run(input int n);
        int pick;
        repeat (n) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
                send_item(random_access(CMD_READ));
            end else if (pick < 18) begin
                send_item(random_access(CMD_WRITE));
            end else if (pick == 18) begin
                send_item(random_access(key_command(key_pos)));
            end else begin
                send_item(random_access(wrong_command(key_pos)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Data accesses while seeking, a bad first bit, a short partial key
    // dropped by a read, and a partial key broken by a wrong bit.
    task automatic test_seek_mode_accesses();
        t_in acc;
        acc         = '1;
        acc.command = CMD_READ;
        send_item(acc);
        acc           = '0;
        acc.command   = CMD_WRITE;
        acc.write_bit = 1'b1;
        send_item(acc);
        send_item(random_access(wrong_command(0)));
        send_key_run(3, '1);
        send_item(random_access(CMD_READ));
        send_key_run(1, '0);
        send_item(random_access(wrong_command(key_pos)));
        send_item(random_access(CMD_WRITE));
    endtask

    // Unlock with every time field at its widest value, shift all 64 bits
    // out, then read once more after the session has closed.
    task automatic test_unlock_max_stamp();
        send_sync();
        send_key_run(KEY_BITS, '1);
        repeat (KEY_BITS + 1) send_item(random_access(CMD_READ));
    endtask

    // Unlock with all time fields zero, then reads and a write around a matching
    // key bit and a breaking key bit while in calendar mode.
    task automatic test_calendar_pattern_bits();
        send_sync();
        send_key_run(KEY_BITS, '0);
        repeat (5) send_item(random_access(CMD_READ));
        send_item(random_access(CMD_WRITE));
        send_item(random_access(key_command(key_pos)));
        repeat (3) send_item(random_access(CMD_READ));
        send_item(random_access(wrong_command(key_pos)));
        send_item(random_access(CMD_READ));
    endtask

    // Finish the key from the middle of a calendar session, so the time is
    // latched again, then read the new snapshot out.
    task automatic test_recapture_in_calendar();
        send_sync();
        send_key_run(KEY_BITS, random_access(CMD_ZERO));
        repeat (10) send_item(random_access(CMD_READ));
        send_key_run(KEY_BITS - key_pos, random_access(CMD_ZERO));
        repeat (KEY_BITS) send_item(random_access(CMD_READ));
    endtask

    // A whole session of writes with alternating data, then a read that
    // finds the unit seeking again.
    task automatic test_write_session();
        t_in acc;
        send_sync();
        send_key_run(KEY_BITS, random_access(CMD_ZERO));
        for (int i = 0; i < KEY_BITS; i++) begin
            acc           = random_access(CMD_WRITE);
            acc.write_bit = i[0];
            send_item(acc);
        end
        send_item(random_access(CMD_READ));
    endtask

    // Mostly full unlock-and-readout sessions with random content; the rest
    // broken keys and plain noise.
    task automatic test_random_traffic(input int n_items);
        int stop_at;
        int kind;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                if (kind != 5) begin
                    send_sync();
                end
                send_key_run(KEY_BITS, random_access(CMD_ZERO));
                send_data_run($urandom_range(1, 70));
            end else if (kind < 8) begin
                send_sync();
                send_key_run($urandom_range(1, KEY_BITS - 1), random_access(CMD_ZERO));
                send_item(random_access(wrong_command(key_pos)));
            end else begin
                repeat ($urandom_range(1, 8)) send_item(random_access(2'($urandom_range(0, 3))));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall at the rate of the current phase
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Result check: compare each output transaction with the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (awaited_outputs.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected result: read_bit=%0b calendar_mode=%0b",
                             out_data.read_bit, out_data.calendar_mode);
                end
                fail_count++;
            end else begin
                oldest_expected = awaited_outputs.pop_front();
                if (out_data.read_bit !== oldest_expected.read_bit ||
                    out_data.calendar_mode !== oldest_expected.calendar_mode) begin
                    if (fail_count < 10) begin
                        $display("mismatch: expected read_bit=%0b calendar_mode=%0b, got %0b %0b",
                                 oldest_expected.read_bit, oldest_expected.calendar_mode,
                                 out_data.read_bit, out_data.calendar_mode);
                    end
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        // Hold reset, then release it at an edge.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_seek_mode_accesses();
        test_unlock_max_stamp();
        test_calendar_pattern_bits();
        test_recapture_in_calendar();
        test_write_session();

        // Random traffic, one phase per idle mix.
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        test_random_traffic(25);
        sender_idle_pct    = 51;
        receiver_stall_pct = 0;
        test_random_traffic(25);
        sender_idle_pct    = 0;
        receiver_stall_pct = 51;
        test_random_traffic(25);
        sender_idle_pct    = 23;
        receiver_stall_pct = 23;
        test_random_traffic(25);

        // Drop valid, drain the outstanding results, then allow for latency.
        in_valid <= 1'b0;
        while (awaited_outputs.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/phcsu_pkg.sv
hdl/phcsu_snap.sv
hdl/phcsu_seq.sv
hdl/phantom_clock_serial_unlock_unit.sv
bench/phantom_clock_serial_unlock_unit_test.sv
